// ----- rtl/lgsts_pkg.sv -----
// ----------------------------------------------------------------------------
// lgsts_pkg
// Shared types and constants of the light gate speed trap with statistics.
// ----------------------------------------------------------------------------
package lgsts_pkg;

  // field widths
  localparam int CMD_W    = 2;
  localparam int TS_W     = 32;
  localparam int DIST_W   = 10;
  localparam int KIND_W   = 3;
  localparam int COUNT_W  = 7;
  localparam int SPEED_W  = 34;
  localparam int SUM_W    = 41;

  // shared divider widths
  localparam int DIVIDEND_W = SUM_W;
  localparam int DIVISOR_W  = TS_W;

  // scale from mm over us to 0.1 mm/s
  localparam logic [23:0] SPEED_SCALE = 24'd10000000;
  // largest value the sample counter holds
  localparam int COUNT_LIMIT = 127;
  // gate distance after reset
  localparam logic [DIST_W-1:0] DIST_RESET = 10'd100;

  // request commands
  localparam logic [CMD_W-1:0] CMD_FRONT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BACK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REPORT = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_MEASURE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REPORT  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ZERO    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FULL    = 3'd4;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_UPD,
    ST_EMIT
  } lgsts_state_t;

  // divider start request
  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } lgsts_div_req_t;

  // divider status
  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } lgsts_div_rsp_t;

endpackage

// ----- rtl/lgsts_div.sv -----
// ----------------------------------------------------------------------------
// lgsts_div
// Restoring divider, one quotient bit per cycle, shared by speed and average.
// ----------------------------------------------------------------------------
module lgsts_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lgsts_pkg::lgsts_div_req_t req,
  output lgsts_pkg::lgsts_div_rsp_t rsp
);

  localparam int DD_W  = lgsts_pkg::DIVIDEND_W;
  localparam int DS_W  = lgsts_pkg::DIVISOR_W;
  localparam int CNT_W = $clog2(DD_W + 1);

  logic [DS_W-1:0]  rem_r, rem_nxt;
  logic [DD_W-1:0]  quo_r, quo_nxt;
  logic [DS_W-1:0]  divisor_r, divisor_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [DS_W:0]    shifted;
  logic             fits;
  logic [DS_W:0]    diff;

  // one trial subtraction
  always_comb begin
    shifted = {rem_r, quo_r[DD_W-1]};
    fits    = shifted >= {1'b0, divisor_r};
    diff    = shifted - {1'b0, divisor_r};
  end

  // step control
  always_comb begin
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    divisor_nxt = divisor_r;
    cnt_nxt     = cnt_r;
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    if (req.start) begin
      rem_nxt     = '0;
      quo_nxt     = req.dividend;
      divisor_nxt = req.divisor;
      cnt_nxt     = CNT_W'(DD_W);
      busy_nxt    = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DS_W-1:0] : shifted[DS_W-1:0];
      quo_nxt = {quo_r[DD_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    divisor_r <= divisor_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ----- rtl/light_gate_speed_trap_stats.sv -----
// ----------------------------------------------------------------------------
// light_gate_speed_trap_stats
// Sequence: a request is taken in IDLE and decoded in EVAL; a measurement or report
//   then runs the 41 steps of the shared restoring divider in DIV, updates in UPD and
//   is emitted in EMIT; a rejection goes from EVAL straight to EMIT. A new request is
//   taken only in IDLE, after the last one is through; a stalled result holds it back.
// Reset: synchronous active-low; trap disarmed, statistics cleared, distance 100.
// ----------------------------------------------------------------------------
module light_gate_speed_trap_stats #(
  parameter int MAX_SAMPLES = 100
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // gate distance register
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lgsts_pkg::DIST_W-1:0]          cfg_gate_distance_mm,
  // requests
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [lgsts_pkg::CMD_W-1:0]           in_command,
  input  logic [lgsts_pkg::TS_W-1:0]            in_timestamp_us,
  // results
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [lgsts_pkg::KIND_W-1:0]          out_result_kind,
  output logic [lgsts_pkg::COUNT_W-1:0]         out_sample_number,
  output logic [lgsts_pkg::SPEED_W-1:0]         out_speed_value,
  output logic [lgsts_pkg::SPEED_W-1:0]         out_speed_maximum,
  output logic [lgsts_pkg::SPEED_W-1:0]         out_speed_minimum
);

  localparam int CMD_W   = lgsts_pkg::CMD_W;
  localparam int TS_W    = lgsts_pkg::TS_W;
  localparam int DIST_W  = lgsts_pkg::DIST_W;
  localparam int KIND_W  = lgsts_pkg::KIND_W;
  localparam int COUNT_W = lgsts_pkg::COUNT_W;
  localparam int SPEED_W = lgsts_pkg::SPEED_W;
  localparam int SUM_W   = lgsts_pkg::SUM_W;
  localparam int DD_W    = lgsts_pkg::DIVIDEND_W;
  localparam int DS_W    = lgsts_pkg::DIVISOR_W;
  localparam int FULL_AT = (MAX_SAMPLES < lgsts_pkg::COUNT_LIMIT) ? MAX_SAMPLES
                                                                 : lgsts_pkg::COUNT_LIMIT;

  lgsts_pkg::lgsts_state_t state_r, state_nxt;

  logic [DIST_W-1:0]  dist_r, dist_nxt;
  logic [CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [TS_W-1:0]    ts_r, ts_nxt;
  logic [TS_W-1:0]    front_ts_r, front_ts_nxt;
  logic               armed_r, armed_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [SPEED_W-1:0] max_r, max_nxt;
  logic [SPEED_W-1:0] min_r, min_nxt;
  logic               is_meas_r, is_meas_nxt;

  // staged result
  logic [KIND_W-1:0]  res_kind_r, res_kind_nxt;
  logic [COUNT_W-1:0] res_num_r, res_num_nxt;
  logic [SPEED_W-1:0] res_val_r, res_val_nxt;
  logic [SPEED_W-1:0] res_max_r, res_max_nxt;
  logic [SPEED_W-1:0] res_min_r, res_min_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]  out_kind_r, out_kind_nxt;
  logic [COUNT_W-1:0] out_num_r, out_num_nxt;
  logic [SPEED_W-1:0] out_val_r, out_val_nxt;
  logic [SPEED_W-1:0] out_max_r, out_max_nxt;
  logic [SPEED_W-1:0] out_min_r, out_min_nxt;

  logic [TS_W-1:0]    interval;
  logic [SPEED_W-1:0] product;
  logic [SPEED_W-1:0] quot_speed;
  logic               slot_free;

  lgsts_pkg::lgsts_div_req_t div_req;
  lgsts_pkg::lgsts_div_rsp_t div_rsp;

  lgsts_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // elapsed time and distance scaling
  assign interval   = ts_r - front_ts_r;
  assign product    = SPEED_W'(dist_r) * SPEED_W'(lgsts_pkg::SPEED_SCALE);
  assign quot_speed = div_rsp.quotient[SPEED_W-1:0];
  assign slot_free  = !out_valid_r || out_ready;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == lgsts_pkg::ST_IDLE);

  // sequencer and statistics update
  always_comb begin
    state_nxt     = state_r;
    dist_nxt      = dist_r;
    cmd_nxt       = cmd_r;
    ts_nxt        = ts_r;
    front_ts_nxt  = front_ts_r;
    armed_nxt     = armed_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    max_nxt       = max_r;
    min_nxt       = min_r;
    is_meas_nxt   = is_meas_r;
    res_kind_nxt  = res_kind_r;
    res_num_nxt   = res_num_r;
    res_val_nxt   = res_val_r;
    res_max_nxt   = res_max_r;
    res_min_nxt   = res_min_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_num_nxt   = out_num_r;
    out_val_nxt   = out_val_r;
    out_max_nxt   = out_max_r;
    out_min_nxt   = out_min_r;
    div_req       = '0;

    if (cfg_valid && cfg_ready) begin
      dist_nxt = cfg_gate_distance_mm;
    end

    // result taken downstream
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      lgsts_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_command;
          ts_nxt    = in_timestamp_us;
          state_nxt = lgsts_pkg::ST_EVAL;
        end
      end
      lgsts_pkg::ST_EVAL: begin
        state_nxt   = lgsts_pkg::ST_IDLE;
        res_num_nxt = '0;
        res_val_nxt = '0;
        res_max_nxt = '0;
        res_min_nxt = '0;
        priority if (cmd_r == lgsts_pkg::CMD_FRONT) begin
          front_ts_nxt = ts_r;
          armed_nxt    = 1'b1;
        end else if (cmd_r == lgsts_pkg::CMD_BACK) begin
          if (armed_r) begin
            armed_nxt = 1'b0;
            priority if (interval == '0) begin
              res_kind_nxt = lgsts_pkg::KIND_ZERO;
              state_nxt    = lgsts_pkg::ST_EMIT;
            end else if (count_r >= COUNT_W'(FULL_AT)) begin
              res_kind_nxt = lgsts_pkg::KIND_FULL;
              res_num_nxt  = count_r;
              state_nxt    = lgsts_pkg::ST_EMIT;
            end else begin
              div_req.start    = 1'b1;
              div_req.dividend = DD_W'(product);
              div_req.divisor  = interval;
              is_meas_nxt      = 1'b1;
              state_nxt        = lgsts_pkg::ST_DIV;
            end
          end
        end else if (cmd_r == lgsts_pkg::CMD_REPORT) begin
          if (count_r == '0) begin
            res_kind_nxt = lgsts_pkg::KIND_EMPTY;
            state_nxt    = lgsts_pkg::ST_EMIT;
          end else begin
            // start the average divide and clear the statistics
            div_req.start    = 1'b1;
            div_req.dividend = sum_r;
            div_req.divisor  = DS_W'(count_r);
            is_meas_nxt      = 1'b0;
            res_kind_nxt     = lgsts_pkg::KIND_REPORT;
            res_num_nxt      = count_r;
            res_max_nxt      = max_r;
            res_min_nxt      = min_r;
            count_nxt        = '0;
            sum_nxt          = '0;
            max_nxt          = '0;
            min_nxt          = '1;
            state_nxt        = lgsts_pkg::ST_DIV;
          end
        end else begin
          state_nxt = lgsts_pkg::ST_IDLE;
        end
      end
      lgsts_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = lgsts_pkg::ST_UPD;
        end
      end
      lgsts_pkg::ST_UPD: begin
        res_val_nxt = quot_speed;
        if (is_meas_r) begin
          count_nxt    = count_r + 1'b1;
          sum_nxt      = sum_r + SUM_W'(quot_speed);
          if (quot_speed > max_r) max_nxt = quot_speed;
          if (quot_speed < min_r) min_nxt = quot_speed;
          res_kind_nxt = lgsts_pkg::KIND_MEASURE;
          res_num_nxt  = count_r + 1'b1;
        end
        state_nxt = lgsts_pkg::ST_EMIT;
      end
      lgsts_pkg::ST_EMIT: begin
        // wait for the output register to free up
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_num_nxt   = res_num_r;
          out_val_nxt   = res_val_r;
          out_max_nxt   = res_max_r;
          out_min_nxt   = res_min_r;
          state_nxt     = lgsts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lgsts_pkg::ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lgsts_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control and statistics registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r      <= lgsts_pkg::DIST_RESET;
      front_ts_r  <= '0;
      armed_r     <= 1'b0;
      count_r     <= '0;
      sum_r       <= '0;
      max_r       <= '0;
      min_r       <= '1;
      out_valid_r <= 1'b0;
    end else begin
      dist_r      <= dist_nxt;
      front_ts_r  <= front_ts_nxt;
      armed_r     <= armed_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      max_r       <= max_nxt;
      min_r       <= min_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    ts_r       <= ts_nxt;
    is_meas_r  <= is_meas_nxt;
    res_kind_r <= res_kind_nxt;
    res_num_r  <= res_num_nxt;
    res_val_r  <= res_val_nxt;
    res_max_r  <= res_max_nxt;
    res_min_r  <= res_min_nxt;
    out_kind_r <= out_kind_nxt;
    out_num_r  <= out_num_nxt;
    out_val_r  <= out_val_nxt;
    out_max_r  <= out_max_nxt;
    out_min_r  <= out_min_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_kind_r;
  assign out_sample_number = out_num_r;
  assign out_speed_value   = out_val_r;
  assign out_speed_maximum = out_max_r;
  assign out_speed_minimum = out_min_r;

`ifndef SYNTHESIS
  // divider is never restarted mid-way
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // divider finishes only while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == lgsts_pkg::ST_DIV))
    else $error("divider done outside divide state");

  // sample count stays within the store limit
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(FULL_AT))
    else $error("sample count beyond limit");

  // empty statistics hold their cleared values
  a_empty_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> ((sum_r == '0) && (max_r == '0) && (min_r == '1)))
    else $error("statistics not clear while empty");

  // stored minimum never exceeds stored maximum
  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> (min_r <= max_r))
    else $error("minimum above maximum");
`endif

endmodule
